@@ rtl/core/cprg_pkg.sv @@
// Package: item types, register indexes and constants of the primary ray generator.
package cprg_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_PITCH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_C      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_D      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_E      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM_F      = 3'd7;

    localparam logic [31:0] PITCH_RST = 32'h0001_0000;
    localparam logic [63:0] HALF_RST  = 64'h0001_0000_0001_0000;
    localparam logic [63:0] XF_A_RST  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] XF_B_RST  = 64'h0;
    localparam logic [63:0] XF_C_RST  = 64'h0000_0000_0001_0000;
    localparam logic [63:0] XF_D_RST  = 64'h0;
    localparam logic [63:0] XF_E_RST  = 64'h0;
    localparam logic [63:0] XF_F_RST  = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               saturated;
    } out_item_t;

    // travels alongside the magnitudes through the normalizer
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0]       neg;
        logic             flag;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic [2:0][29:0] mag;
        side_t            side;
    } nrm_in_t;

endpackage

@@ rtl/core/camera_primary_ray_generator.sv @@
// Top level: pinhole camera primary ray generator.
// Pipeline: 6 front stages and 35 normalizer stages between item acceptance and result valid.
// Throughput: one item per cycle; each stage holds on its own when the next one is full.
// The depth is set by the 32-digit square root and 32-bit division, two steps per stage.
// Reset (aresetn low, synchronous): clears all valid bits and restores register defaults.
module camera_primary_ray_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cprg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cprg_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cprg_pkg::out_item_t                 m_item
);
    import cprg_pkg::*;

    localparam int               NF    = 6;
    localparam logic [15:0]      CMASK = 16'((32'd1 << COORD_BITS) - 1);
    localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (v < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    logic [31:0] pitch_reg;
    logic [63:0] half_reg;
    logic [63:0] xf_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= PITCH_RST;
            half_reg  <= HALF_RST;
            xf_reg[0] <= XF_A_RST;
            xf_reg[1] <= XF_B_RST;
            xf_reg[2] <= XF_C_RST;
            xf_reg[3] <= XF_D_RST;
            xf_reg[4] <= XF_E_RST;
            xf_reg[5] <= XF_F_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PIXEL_PITCH:  pitch_reg <= cfg_wdata[31:0];
                CFG_HALF_EXTENTS: half_reg  <= cfg_wdata;
                CFG_XFORM_A:      xf_reg[0] <= cfg_wdata;
                CFG_XFORM_B:      xf_reg[1] <= cfg_wdata;
                CFG_XFORM_C:      xf_reg[2] <= cfg_wdata;
                CFG_XFORM_D:      xf_reg[3] <= cfg_wdata;
                CFG_XFORM_E:      xf_reg[4] <= cfg_wdata;
                CFG_XFORM_F:      xf_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [31:0] mat [3][3];
    logic signed [31:0] trn [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mat[i][0] = xf_reg[2*i][63:32];
            mat[i][1] = xf_reg[2*i][31:0];
            mat[i][2] = xf_reg[2*i+1][63:32];
            trn[i]    = xf_reg[2*i+1][31:0];
        end
    end

    // elastic front pipeline
    logic [NF-1:0] fv_reg;
    logic [NF-1:0] fen;
    logic          nrm_ready;

    always_comb begin
        fen[NF-1] = !fv_reg[NF-1] || nrm_ready;
        for (int k = NF - 2; k >= 0; k--) begin
            fen[k] = !fv_reg[k] || fen[k+1];
        end
    end

    assign s_ready = fen[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else begin
            if (fen[0]) begin
                fv_reg[0] <= s_valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (fen[k]) begin
                    fv_reg[k] <= fv_reg[k-1];
                end
            end
        end
    end

    logic               flag_reg [NF-1];
    logic signed [31:0] w_reg [2];
    logic signed [63:0] prod_reg [3][2];
    logic signed [65:0] pt_reg [3];
    logic signed [32:0] d_reg [3];
    logic [32:0]        a_reg [3];
    logic [2:0]         neg_reg;
    logic [5:0]         pos_reg;
    logic               zero_reg;
    nrm_in_t            nrm_in_reg;

    // stage 1: canvas point, floor((2*half - (2*coord+1)*pitch) / 2)
    logic [15:0]        col_m, row_m;
    logic [48:0]        pc_x, pc_y;
    logic signed [50:0] dx, dy, hx, hy;
    logic [32:0]        sw_x, sw_y;

    always_comb begin
        col_m = {4'd0, s_item.pixel_col} & CMASK;
        row_m = {4'd0, s_item.pixel_row} & CMASK;
        pc_x  = 49'({col_m, 1'b1}) * 49'(pitch_reg);
        pc_y  = 49'({row_m, 1'b1}) * 49'(pitch_reg);
        dx    = $signed({{18{half_reg[63]}}, half_reg[63:32], 1'b0}) - $signed({2'b00, pc_x});
        dy    = $signed({{18{half_reg[31]}}, half_reg[31:0], 1'b0}) - $signed({2'b00, pc_y});
        hx    = dx >>> 1;
        hy    = dy >>> 1;
        sw_x  = sat32(66'(hx));
        sw_y  = sat32(66'(hy));
    end

    always_ff @(posedge aclk) begin
        if (fen[0]) begin
            w_reg[0]    <= sw_x[31:0];
            w_reg[1]    <= sw_y[31:0];
            flag_reg[0] <= sw_x[32] | sw_y[32];
        end
    end

    // stage 2: products with the x and y columns
    always_ff @(posedge aclk) begin
        if (fen[1]) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i][0] <= mat[i][0] * w_reg[0];
                prod_reg[i][1] <= mat[i][1] * w_reg[1];
            end
            flag_reg[1] <= flag_reg[0];
        end
    end

    // stage 3: exact sum with the z term (w_z = -1.0), rounded half up
    logic signed [65:0] acc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = 66'(prod_reg[i][0]) + 66'(prod_reg[i][1])
                   - (66'(mat[i][2]) <<< FRAC_BITS) + RND;
        end
    end

    always_ff @(posedge aclk) begin
        if (fen[2]) begin
            for (int i = 0; i < 3; i++) begin
                pt_reg[i] <= acc[i] >>> FRAC_BITS;
            end
            flag_reg[2] <= flag_reg[1];
        end
    end

    // stage 4: translate, saturate, difference from the origin
    logic [32:0] sp [3];
    logic [2:0]  sp_f;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp[i]   = sat32(pt_reg[i] + 66'(trn[i]));
            sp_f[i] = sp[i][32];
        end
    end

    always_ff @(posedge aclk) begin
        if (fen[3]) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= 33'($signed(sp[i][31:0])) - 33'(trn[i]);
            end
            flag_reg[3] <= flag_reg[2] | (|sp_f);
        end
    end

    // stage 5: magnitudes, their maximum and its leading one
    logic [32:0] mag [3];
    logic [2:0]  negc;
    logic [32:0] mx;
    logic [5:0]  pos;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            negc[i] = d_reg[i][32];
            mag[i]  = negc[i] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
        end
        mx = mag[0];
        if (mag[1] > mx) begin
            mx = mag[1];
        end
        if (mag[2] > mx) begin
            mx = mag[2];
        end
        pos = '0;
        for (int b = 0; b < 33; b++) begin
            if (mx[b]) begin
                pos = 6'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fen[4]) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= mag[i];
            end
            neg_reg     <= negc;
            pos_reg     <= pos;
            zero_reg    <= (mx == '0);
            flag_reg[4] <= flag_reg[3];
        end
    end

    // stage 6: common shift so the largest magnitude lands in [2^29, 2^30)
    logic [32:0] shd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shd[i] = (pos_reg >= 6'd29) ? (a_reg[i] >> (pos_reg - 6'd29))
                                        : (a_reg[i] << (6'd29 - pos_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (fen[5]) begin
            for (int i = 0; i < 3; i++) begin
                nrm_in_reg.mag[i]      <= shd[i][29:0];
                nrm_in_reg.side.org[i] <= trn[i];
            end
            nrm_in_reg.side.neg  <= neg_reg;
            nrm_in_reg.side.flag <= flag_reg[4];
            nrm_in_reg.side.zero <= zero_reg;
        end
    end

    cprg_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fv_reg[NF-1]),
        .in_ready  (nrm_ready),
        .in_data   (nrm_in_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

`ifndef SYNTHESIS
    // an empty output register frees every stage behind it
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_zero_dir_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.dir_x == 32'sd0 && m_item.dir_y == 32'sd0
         && m_item.dir_z == 32'sd0) |-> m_item.saturated)
        else $error("zero direction without flag");

    a_dir_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.dir_x <= 32'sd1073741824 && m_item.dir_x >= -32'sd1073741824
                  && m_item.dir_y <= 32'sd1073741824 && m_item.dir_y >= -32'sd1073741824
                  && m_item.dir_z <= 32'sd1073741824 && m_item.dir_z >= -32'sd1073741824))
        else $error("direction component above unit length");
`endif

endmodule

@@ rtl/core/cprg_norm.sv @@
// Normalizer: sum of squares, pipelined square root and pipelined division per component.
module cprg_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cprg_pkg::nrm_in_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cprg_pkg::out_item_t out_item
);
    import cprg_pkg::*;

    localparam int SQ_ST = 16;               // two root digits per stage
    localparam int DV_ST = 16;               // two quotient bits per stage
    localparam int SQ0   = 2;
    localparam int DV0   = SQ0 + SQ_ST;
    localparam int NS    = DV0 + DV_ST + 1;

    function automatic logic [127:0] sq_step(input logic [63:0] s, input logic [63:0] r,
                                             input logic [63:0] b);
        logic [63:0] t;
        t = r + b;
        if (s >= t) begin
            return {s - t, (r >> 1) + b};
        end
        return {s, r >> 1};
    endfunction

    function automatic logic [64:0] dv_step(input logic [63:0] rem, input logic [31:0] len,
                                            input logic [5:0] sh);
        logic [63:0] dd;
        dd = {32'd0, len} << sh;
        if (rem >= dd) begin
            return {rem - dd, 1'b1};
        end
        return {rem, 1'b0};
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic [59:0]      sq_reg [3];
    logic [61:0]      sum_reg;
    logic [63:0]      sqs_reg [SQ_ST];
    logic [63:0]      sqr_reg [SQ_ST];
    logic [63:0]      rem_reg [DV_ST][3];
    logic [31:0]      q_reg [DV_ST][3];
    logic [31:0]      dl_reg [DV_ST];
    logic [2:0][29:0] magc_reg [DV0];
    side_t            side_reg [NS-1];
    out_item_t        out_reg;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // squares, then their sum
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 60'(in_data.mag[i]) * 60'(in_data.mag[i]);
            end
            side_reg[0] <= in_data.side;
            magc_reg[0] <= in_data.mag;
        end
        if (en[1]) begin
            sum_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        end
    end

    for (genvar k = 1; k < NS - 1; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k < DV0; k++) begin : g_mag
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                magc_reg[k] <= magc_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
        logic [63:0]  s_in;
        logic [63:0]  r_in;
        logic [127:0] t0;
        logic [127:0] t1;
        if (k == 0) begin : g_first
            assign s_in = {2'b00, sum_reg};
            assign r_in = '0;
        end else begin : g_next
            assign s_in = sqs_reg[k-1];
            assign r_in = sqr_reg[k-1];
        end
        assign t0 = sq_step(s_in, r_in, 64'd1 << (62 - 4 * k));
        assign t1 = sq_step(t0[127:64], t0[63:0], 64'd1 << (60 - 4 * k));
        always_ff @(posedge aclk) begin
            if (en[SQ0+k]) begin
                sqs_reg[k] <= t1[127:64];
                sqr_reg[k] <= t1[63:0];
            end
        end
    end

    for (genvar k = 0; k < DV_ST; k++) begin : g_div
        logic [31:0] len_in;
        if (k == 0) begin : g_first
            assign len_in = sqr_reg[SQ_ST-1][31:0];
        end else begin : g_next
            assign len_in = dl_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en[DV0+k]) begin
                dl_reg[k] <= len_in;
            end
        end
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [63:0] rem_in;
            logic [31:0] q_in;
            logic [64:0] u0;
            logic [64:0] u1;
            if (k == 0) begin : g_first
                // rounding: add half the divisor before dividing
                assign rem_in = {4'd0, magc_reg[DV0-1][i], 30'd0} + 64'(len_in >> 1);
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1][i];
                assign q_in   = q_reg[k-1][i];
            end
            assign u0 = dv_step(rem_in, len_in, 6'(31 - 2 * k));
            assign u1 = dv_step(u0[64:1], len_in, 6'(30 - 2 * k));
            always_ff @(posedge aclk) begin
                if (en[DV0+k]) begin
                    rem_reg[k][i] <= u1[64:1];
                    q_reg[k][i]   <= {q_in[29:0], u0[0], u1[0]};
                end
            end
        end
    end

    // sign restore; a zero-length difference gives a zero direction
    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            out_reg.origin_x  <= side_reg[NS-2].org[0];
            out_reg.origin_y  <= side_reg[NS-2].org[1];
            out_reg.origin_z  <= side_reg[NS-2].org[2];
            out_reg.dir_x     <= side_reg[NS-2].zero ? '0 :
                                 side_reg[NS-2].neg[0] ? -q_reg[DV_ST-1][0] : q_reg[DV_ST-1][0];
            out_reg.dir_y     <= side_reg[NS-2].zero ? '0 :
                                 side_reg[NS-2].neg[1] ? -q_reg[DV_ST-1][1] : q_reg[DV_ST-1][1];
            out_reg.dir_z     <= side_reg[NS-2].zero ? '0 :
                                 side_reg[NS-2].neg[2] ? -q_reg[DV_ST-1][2] : q_reg[DV_ST-1][2];
            out_reg.saturated <= side_reg[NS-2].flag | side_reg[NS-2].zero;
        end
    end

endmodule
